>>> hdl/sragc_pkg.sv
package sragc_pkg;

    // Gain limits and step sizes, in dB
    localparam logic [3:0] LNA_STEP_DB  = 4'd14;
    localparam logic [5:0] MIXER_MAX_DB = 6'd40;
    localparam logic [5:0] IF_MAX_DB    = 6'd62;

    // Gain state after reset
    localparam logic [3:0] LNA_RESET_DB   = 4'd14;
    localparam logic [5:0] MIXER_RESET_DB = 6'd24;
    localparam logic [5:0] IF_RESET_DB    = 6'd20;

    // Limit registers
    localparam int          CFG_DATA_W         = 8;
    localparam logic        REG_UPPER_LIMIT    = 1'b0;
    localparam logic        REG_LOWER_LIMIT    = 1'b1;
    localparam logic [7:0]  UPPER_LIMIT_RESET  = 8'hF1;   // -15 dB
    localparam logic [7:0]  LOWER_LIMIT_RESET  = 8'hE7;   // -25 dB

    // The three stage gains as one group
    typedef struct packed {
        logic [3:0] lna_db;
        logic [5:0] mixer_db;
        logic [5:0] if_db;
    } gain_t;

    // Both limits as one group
    typedef struct packed {
        logic signed [7:0] upper_db;
        logic signed [7:0] lower_db;
    } limits_t;

endpackage

>>> hdl/sragc_cfg.sv
module sragc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [sragc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output sragc_pkg::limits_t                  limits
);

    logic [7:0] upper_reg;
    logic [7:0] lower_reg;

    // Limit registers, written without handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= sragc_pkg::UPPER_LIMIT_RESET;
            lower_reg <= sragc_pkg::LOWER_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                sragc_pkg::REG_UPPER_LIMIT: upper_reg <= cfg_wdata;
                sragc_pkg::REG_LOWER_LIMIT: lower_reg <= cfg_wdata;
                default:                    upper_reg <= upper_reg;
            endcase
        end
    end

    assign limits.upper_db = upper_reg;
    assign limits.lower_db = lower_reg;

endmodule

>>> hdl/sragc_step.sv
module sragc_step
(
    input  logic signed [15:0]  power,
    input  sragc_pkg::limits_t  limits,
    input  sragc_pkg::gain_t    cur,
    output sragc_pkg::gain_t    nxt,
    output logic [2:0]          mask
);

    logic signed [15:0] up_q8;
    logic signed [15:0] lo_q8;
    logic               above;
    logic               below;
    logic [16:0]        diff_up;
    logic [16:0]        diff_lo;
    logic [7:0]         mag;

    // raise path
    logic [3:0]         r_lna;
    logic [7:0]         r_c1;
    logic [8:0]         r_mix_sum;
    logic [5:0]         r_mix;
    logic [8:0]         r_c2_full;
    logic [7:0]         r_c2;
    logic [8:0]         r_if_sum;
    logic [5:0]         r_if;

    // reduce path
    logic [7:0]         l_if_sub;
    logic [5:0]         l_if;
    logic [7:0]         l_m2;
    logic [7:0]         l_mix_sub;
    logic [5:0]         l_mix;
    logic [7:0]         l_m3;
    logic [3:0]         l_lna;

    // Limit compare on Q8.8; correction magnitude is the difference, truncated
    always_comb
    begin
        up_q8   = {limits.upper_db, 8'h00};
        lo_q8   = {limits.lower_db, 8'h00};
        above   = power > up_q8;
        below   = power < lo_q8;
        diff_up = {power[15], power} - {up_q8[15], up_q8};
        diff_lo = {lo_q8[15], lo_q8} - {power[15], power};
        if (above)
            mag = diff_up[15:8];
        else if (below)
            mag = diff_lo[15:8];
        else
            mag = 8'd0;
    end

    // Raise: LNA first, then mixer in 8 dB steps, then IF in 2 dB steps
    always_comb
    begin
        if (mag >= {4'd0, sragc_pkg::LNA_STEP_DB} && cur.lna_db < sragc_pkg::LNA_STEP_DB)
        begin
            r_lna = sragc_pkg::LNA_STEP_DB;
            r_c1  = mag - {4'd0, sragc_pkg::LNA_STEP_DB};
        end
        else
        begin
            r_lna = cur.lna_db;
            r_c1  = mag;
        end
        r_mix_sum = {3'd0, cur.mixer_db} + {1'b0, r_c1[7:3], 3'b000};
        r_mix     = (r_mix_sum > {3'd0, sragc_pkg::MIXER_MAX_DB}) ?
                    sragc_pkg::MIXER_MAX_DB : r_mix_sum[5:0];
        // leftover after the mixer cap
        r_c2_full = {1'b0, r_c1} + {3'd0, cur.mixer_db} - {3'd0, r_mix};
        r_c2      = r_c2_full[7:0];
        r_if_sum  = {3'd0, cur.if_db} + {1'b0, r_c2[7:1], 1'b0};
        r_if      = (r_if_sum > {3'd0, sragc_pkg::IF_MAX_DB}) ?
                    sragc_pkg::IF_MAX_DB : r_if_sum[5:0];
    end

    // Reduce: IF first, then mixer, then LNA, each floored at zero
    always_comb
    begin
        l_if_sub  = {mag[7:1], 1'b0};
        l_if      = ({2'd0, cur.if_db} >= l_if_sub) ?
                    (cur.if_db - l_if_sub[5:0]) : 6'd0;
        l_m2      = mag - {2'd0, cur.if_db} + {2'd0, l_if};
        l_mix_sub = {l_m2[7:3], 3'b000};
        l_mix     = ({2'd0, cur.mixer_db} >= l_mix_sub) ?
                    (cur.mixer_db - l_mix_sub[5:0]) : 6'd0;
        l_m3      = l_m2 - {2'd0, cur.mixer_db} + {2'd0, l_mix};
        // LNA holds 0 or 14, so any whole 14 dB step turns it off
        l_lna     = (l_m3 >= {4'd0, sragc_pkg::LNA_STEP_DB}) ? 4'd0 : cur.lna_db;
    end

    // Upper limit test wins when limits cross
    always_comb
    begin
        if (above)
        begin
            nxt.lna_db   = l_lna;
            nxt.mixer_db = l_mix;
            nxt.if_db    = l_if;
        end
        else if (below)
        begin
            nxt.lna_db   = r_lna;
            nxt.mixer_db = r_mix;
            nxt.if_db    = r_if;
        end
        else
        begin
            nxt = cur;
        end
        mask[0] = nxt.lna_db   != cur.lna_db;
        mask[1] = nxt.mixer_db != cur.mixer_db;
        mask[2] = nxt.if_db    != cur.if_db;
    end

endmodule

>>> hdl/stepped_rf_gain_agc_unit.sv
// Stepped RF gain AGC.
// Input channel (in_valid/in_ready, power_db_q8): one power reading per
// transaction, signed Q8.8 dB. Output channel (out_valid/out_ready): one
// transaction per input carrying the LNA, mixer and IF gains after the
// update plus a mask of which gains moved.
// Limits are written through cfg_wr_en/cfg_addr/cfg_wdata (index 0 upper,
// index 1 lower, whole dB signed); write them only while no transaction is
// in flight.
// Path: the reading passes the input register, then the result register that
// also holds the gain state; out_valid rises once the result register has
// loaded the update.
// Throughput: one transaction per cycle while out_ready is high; the gain
// update loop through the result register sets that rate.
// Reset: limits -15/-25 dB, gains 14/24/20 dB, both channels empty.
// Stall: with out_ready low the result holds and the input register still
// takes one more reading; in_ready then drops until the result is taken.
module stepped_rf_gain_agc_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [sragc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  power_db_q8,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0]                          lna_gain_db,
    output logic [5:0]                          mixer_gain_db,
    output logic [5:0]                          if_gain_db,
    output logic [2:0]                          changed_mask
);

    sragc_pkg::limits_t limits;
    sragc_pkg::gain_t   gain_reg;
    sragc_pkg::gain_t   gain_next;
    logic               in_valid_reg;
    logic signed [15:0] power_reg;
    logic               out_valid_reg;
    logic [2:0]         mask_reg;
    logic [2:0]         mask_next;
    logic               advance;

    sragc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    sragc_step u_step
    (
        .power  (power_reg),
        .limits (limits),
        .cur    (gain_reg),
        .nxt    (gain_next),
        .mask   (mask_next)
    );

    // Handshake: result slot frees on take, input slot frees on advance
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            power_reg <= power_db_q8;
    end

    // Result register; the gains double as the AGC state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            gain_reg.lna_db   <= sragc_pkg::LNA_RESET_DB;
            gain_reg.mixer_db <= sragc_pkg::MIXER_RESET_DB;
            gain_reg.if_db    <= sragc_pkg::IF_RESET_DB;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                gain_reg      <= gain_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            mask_reg <= mask_next;
    end

    assign out_valid     = out_valid_reg;
    assign lna_gain_db   = gain_reg.lna_db;
    assign mixer_gain_db = gain_reg.mixer_db;
    assign if_gain_db    = gain_reg.if_db;
    assign changed_mask  = mask_reg;

endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT    = 2000;   // cycles with no transaction before giving up
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 140;
    localparam int NUM_PHASES     = 8;

    // One expected or observed output transaction
    typedef struct packed {
        sragc_pkg::gain_t gains;
        logic [2:0]       mask;
    } agc_result_t;

    // Tracks the gain state and limits, and holds predicted gain updates in order
    class gain_tracker;
        logic signed [7:0] upper_db;
        logic signed [7:0] lower_db;
        int                lna_db;
        int                mixer_db;
        int                if_db;
        agc_result_t       expected_gains[$];
        int                mismatches;

        function new();
            upper_db   = sragc_pkg::UPPER_LIMIT_RESET;
            lower_db   = sragc_pkg::LOWER_LIMIT_RESET;
            lna_db     = sragc_pkg::LNA_RESET_DB;
            mixer_db   = sragc_pkg::MIXER_RESET_DB;
            if_db      = sragc_pkg::IF_RESET_DB;
            mismatches = 0;
        endfunction

        function void set_limits(logic signed [7:0] up, logic signed [7:0] lo);
            upper_db = up;
            lower_db = lo;
        endfunction

        function int pending();
            return expected_gains.size();
        endfunction

        // Apply one power reading to the gain state and queue the resulting update
        function void take_power(logic signed [15:0] power);
            int          pw;
            int          up;
            int          lo;
            int          chg;
            int          n;
            int          old_lna;
            int          old_mix;
            int          old_if;
            agc_result_t e;
            pw      = int'(power);
            up      = int'(upper_db) * 256;
            lo      = int'(lower_db) * 256;
            chg     = 0;
            old_lna = lna_db;
            old_mix = mixer_db;
            old_if  = if_db;
            // upper test wins when limits are inverted
            if (pw > up)
                chg = (up - pw) / 256;
            else if (pw < lo)
                chg = (lo - pw) / 256;
            if (chg > 0)
            begin
                // raise: LNA, then mixer, then IF
                if (chg >= 14 && lna_db < 14)
                begin
                    lna_db = 14;
                    chg -= 14;
                end
                n = mixer_db + 8 * (chg / 8);
                if (n > 40)
                    n = 40;
                chg -= n - mixer_db;
                mixer_db = n;
                n = if_db + 2 * (chg / 2);
                if (n > 62)
                    n = 62;
                if_db = n;
            end
            else if (chg < 0)
            begin
                // cut: IF, then mixer, then LNA, each floored at zero
                n = if_db + 2 * (chg / 2);
                if (n < 0)
                    n = 0;
                chg -= n - if_db;
                if_db = n;
                n = mixer_db + 8 * (chg / 8);
                if (n < 0)
                    n = 0;
                chg -= n - mixer_db;
                mixer_db = n;
                n = lna_db + 14 * (chg / 14);
                if (n < 0)
                    n = 0;
                lna_db = n;
            end
            e.gains.lna_db   = lna_db[3:0];
            e.gains.mixer_db = mixer_db[5:0];
            e.gains.if_db    = if_db[5:0];
            e.mask           = {if_db != old_if, mixer_db != old_mix, lna_db != old_lna};
            expected_gains.push_back(e);
        endfunction

        // Compare an output transaction with the oldest predicted update
        function void check_gains(agc_result_t got);
            agc_result_t e;
            if (expected_gains.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected gain update: lna %0d mixer %0d if %0d mask %b",
                             got.gains.lna_db, got.gains.mixer_db, got.gains.if_db, got.mask);
                return;
            end
            e = expected_gains.pop_front();
            if (got.gains.lna_db !== e.gains.lna_db || got.gains.mixer_db !== e.gains.mixer_db
                || got.gains.if_db !== e.gains.if_db || got.mask !== e.mask)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("gain mismatch: exp lna %0d mixer %0d if %0d mask %b,",
                             e.gains.lna_db, e.gains.mixer_db, e.gains.if_db, e.mask);
                    $display("               got lna %0d mixer %0d if %0d mask %b",
                             got.gains.lna_db, got.gains.mixer_db, got.gains.if_db, got.mask);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_addr    = sragc_pkg::REG_UPPER_LIMIT;
    logic [7:0]         cfg_wdata   = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic signed [15:0] power_db_q8 = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [3:0]         lna_gain_db;
    logic [5:0]         mixer_gain_db;
    logic [5:0]         if_gain_db;
    logic [2:0]         changed_mask;

    logic               hold_active = 1'b0;
    int                 idle_pct    = 0;
    int                 stall_pct   = 0;
    int                 n_readings  = 0;
    int                 n_updates   = 0;
    int                 n_settings  = 0;
    gain_tracker        tracker;
    event               holdoff_go;

    stepped_rf_gain_agc_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .power_db_q8   (power_db_q8),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lna_gain_db   (lna_gain_db),
        .mixer_gain_db (mixer_gain_db),
        .if_gain_db    (if_gain_db),
        .changed_mask  (changed_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Output side: random stalls, forced low during a hold-off
    always @(posedge clk)
    begin
        out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end

    // Long output hold-off, counted here
    initial
    begin
        forever
        begin
            @(holdoff_go);
            hold_active <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // Transaction monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tracker.take_power(power_db_q8);
                n_readings++;
            end
            if (out_valid && out_ready)
            begin
                tracker.check_gains({lna_gain_db, mixer_gain_db, if_gain_db, changed_mask});
                n_updates++;
            end
        end
    end

    // Watchdog: gives up after a long run with no transaction
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one reading, with random idle cycles ahead of it
    task automatic send_power(input logic signed [15:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        power_db_q8 <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every predicted update to come out
    task automatic drain_updates();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_limits(input logic signed [7:0] up, input logic signed [7:0] lo);
        drain_updates();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sragc_pkg::REG_UPPER_LIMIT;
        cfg_wdata <= up;
        @(posedge clk);
        cfg_addr  <= sragc_pkg::REG_LOWER_LIMIT;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_limits(up, lo);
        n_settings++;
        @(posedge clk);
    endtask

    // Mostly readings a few dB around one of the limits, some anywhere
    function automatic logic signed [15:0] pick_power(logic signed [7:0] up,
                                                      logic signed [7:0] lo);
        int base;
        int off;
        int v;
        if ($urandom_range(9) < 2)
            return 16'($urandom);
        base = ($urandom_range(1) ? int'(up) : int'(lo)) * 256;
        if ($urandom_range(4) == 0)
            off = int'($urandom_range(96 * 256)) - 48 * 256;
        else
            off = int'($urandom_range(20 * 256)) - 10 * 256;
        v = base + off;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    initial
    begin
        int                up_tbl[NUM_PHASES];
        int                lo_tbl[NUM_PHASES];
        int                basic_pw[16];
        int                inverted_pw[4];
        logic signed [7:0] up;
        logic signed [7:0] lo;
        up_tbl      = '{-15, 127, -128, 0, -40, 60, 0, -20};
        lo_tbl      = '{-25, -128, 127, 0, -60, 20, 0, -30};
        // at/just past the limits, fractional misses, caps, floors, LNA on and off
        basic_pw    = '{-3840, -6400, -3839, -6401, -5000, -8960, 0, 32767,
                        -32768, 32767, -9984, 1280, -9728, 1, -1, -32768};
        inverted_pw = '{0, -32768, -32767, 32767};
        tracker     = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed readings with the limits left at reset
        foreach (basic_pw[i])
            send_power(16'(basic_pw[i]));

        // Lower limit above upper, at the extremes
        write_limits(-8'sd128, 8'sd127);
        foreach (inverted_pw[i])
            send_power(16'(inverted_pw[i]));

        // Random phases over several limit settings and idle and stall mixes
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 6)
            begin
                up = 8'($urandom);
                lo = 8'($urandom);
            end
            else
            begin
                up = 8'(up_tbl[ph]);
                lo = 8'(lo_tbl[ph]);
            end
            write_limits(up, lo);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 0 && k == 40)
                    -> holdoff_go;
                if (ph == 5 && k == 70)
                    drain_updates();
                send_power(pick_power(up, lo));
            end
        end

        drain_updates();
        repeat (6) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.mismatches++;

        $display("Checked %0d gain updates from %0d power readings over %0d limit settings,",
                 n_updates, n_readings, n_settings);
        $display("with idle and stall mixes, one long output hold-off and one full drain pause.");
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
